[hw/rtl/cfpa_pkg.sv]
// shared constants and controller/datapath interface types for the CAN package assembler
package cfpa_pkg;

    // fixed widths and framing constants
    localparam int POS_W             = 10;
    localparam int HEADER_BYTES      = 6;
    localparam int MAX_DATA_BYTES    = 8;
    localparam int FRAME_OVERHEAD    = 4 + 1;
    localparam int LEN_FIELD_BYTES   = 2;
    localparam int FRAME_W           = 32 + 8 + 64;
    localparam int LEFT_W            = 4;
    localparam int PACKAGE_BYTES_DEF = 512;

    // commands from controller to datapath
    typedef struct packed {
        logic latch;     // capture the incoming request
        logic wr_byte;   // write one frame byte at the write position
        logic wr_hdr;    // bump round counter and write the header
        logic rd_en;     // issue a word read
        logic rd_adv;    // read the word after the current one
        logic ld_out;    // move the read word into the output register
        logic reset_wp;  // package done, rewind write position
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic is_drain;
        logic pending;
        logic fits;
        logic byte_last;
        logic word_last;
        logic out_free;
    } t_status;

endpackage

[hw/rtl/cfpa_ctrl.sv]
// controller state machine sequencing frame writes and package emission
module cfpa_ctrl
    import cfpa_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_WRITE,
        S_HDR,
        S_READ,
        S_LOAD
    } t_state;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_status.is_drain) begin
                    n_state = i_status.pending ? S_HDR : S_IDLE;
                end else if (i_status.fits) begin
                    n_state = S_WRITE;
                end else begin
                    // full package goes out first; an empty one cannot take the frame
                    n_state = i_status.pending ? S_HDR : S_IDLE;
                end
            end
            S_WRITE: begin
                o_cmd.wr_byte = 1'b1;
                if (i_status.byte_last) begin
                    n_state = S_IDLE;
                end
            end
            S_HDR: begin
                o_cmd.wr_hdr = 1'b1;
                n_state      = S_READ;
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_LOAD;
            end
            S_LOAD: begin
                if (i_status.out_free) begin
                    o_cmd.ld_out = 1'b1;
                    if (i_status.word_last) begin
                        o_cmd.reset_wp = 1'b1;
                        n_state = i_status.is_drain ? S_IDLE : S_DECIDE;
                    end else begin
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.rd_adv = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/cfpa_datapath.sv]
// datapath: frame shifter, package word memory, header fill and output register
module cfpa_datapath
    import cfpa_pkg::*;
#(
    parameter int PACKAGE_BYTES = PACKAGE_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    input  logic        i_mode,
    input  logic [31:0] i_can_id,
    input  logic [3:0]  i_data_length,
    input  logic [63:0] i_data_bytes,
    input  logic        i_stall,
    output logic        o_valid,
    output logic [63:0] o_package_word,
    output logic [3:0]  o_bytes_valid,
    output logic        o_last_word
);

    localparam int DEPTH = (PACKAGE_BYTES + 7) / 8;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PAD_W = POS_W - AW - 3;

    // package memory, one 64-bit word per row with byte lanes, lane 0 most significant
    logic [63:0] r_mem [DEPTH];
    logic [63:0] r_rd_data;

    logic [FRAME_W-1:0] r_frame;
    logic [LEFT_W-1:0]  r_left;
    logic               r_mode;
    logic [POS_W-1:0]   r_wp;
    logic [31:0]        r_round;
    logic [AW-1:0]      r_rd_ptr;
    logic               r_o_valid;
    logic [63:0]        r_o_word;
    logic [3:0]         r_o_bv;
    logic               r_o_last;

    logic [3:0]       dlen_sat;
    logic [31:0]      round_nx;
    logic [15:0]      len_field;
    logic [AW-1:0]    wr_addr;
    logic [7:0]       wr_be;
    logic [63:0]      wr_data;
    logic             wr_en;
    logic [AW-1:0]    rd_addr;
    logic [POS_W-1:0] word_pos;
    logic [POS_W-1:0] rem_bytes;
    logic             word_last;
    logic [3:0]       word_bv;
    logic [63:0]      word_masked;
    logic             out_free;

    // length saturation on capture
    assign dlen_sat = (i_data_length > 4'(MAX_DATA_BYTES)) ? 4'(MAX_DATA_BYTES)
                                                           : i_data_length;

    // captured frame, shifted out one byte per write
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_frame <= {i_can_id, 4'b0000, dlen_sat, i_data_bytes};
            r_left  <= LEFT_W'(FRAME_OVERHEAD) + dlen_sat;
            r_mode  <= i_mode;
        end else if (i_cmd.wr_byte) begin
            r_frame <= {r_frame[FRAME_W-9:0], 8'h00};
            r_left  <= r_left - 1'b1;
        end
    end

    // write position and round counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= POS_W'(HEADER_BYTES);
            r_round <= '0;
        end else begin
            if (i_cmd.reset_wp) begin
                r_wp <= POS_W'(HEADER_BYTES);
            end else if (i_cmd.wr_byte) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_cmd.wr_hdr) begin
                r_round <= round_nx;
            end
        end
    end

    // header fields
    assign round_nx  = r_round + 32'd1;
    assign len_field = 16'(r_wp - POS_W'(LEN_FIELD_BYTES));

    // memory write port: frame byte or header
    always_comb begin
        wr_en   = i_cmd.wr_byte | i_cmd.wr_hdr;
        wr_addr = r_wp[AW+2:3];
        wr_be   = '0;
        wr_data = {8{r_frame[FRAME_W-1 -: 8]}};
        if (i_cmd.wr_hdr) begin
            wr_addr = '0;
            wr_be   = 8'b0011_1111;
            wr_data = {len_field, round_nx, 16'h0000};
        end else begin
            wr_be[r_wp[2:0]] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            for (int j = 0; j < 8; j++) begin
                if (wr_be[j]) begin
                    r_mem[wr_addr][(7-j)*8 +: 8] <= wr_data[(7-j)*8 +: 8];
                end
            end
        end
    end

    // memory read port with registered data
    assign rd_addr = i_cmd.rd_adv ? r_rd_ptr + 1'b1 : r_rd_ptr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_hdr) begin
            r_rd_ptr <= '0;
        end else if (i_cmd.rd_en) begin
            r_rd_ptr <= rd_addr;
        end
    end

    // valid byte count and tail masking of the word being read out
    assign word_pos  = {{PAD_W{1'b0}}, r_rd_ptr, 3'b000};
    assign rem_bytes = r_wp - word_pos;
    assign word_last = (rem_bytes <= POS_W'(8));
    assign word_bv   = word_last ? rem_bytes[3:0] : 4'd8;

    always_comb begin
        for (int j = 0; j < 8; j++) begin
            word_masked[(7-j)*8 +: 8] = (4'(j) < word_bv) ? r_rd_data[(7-j)*8 +: 8] : 8'h00;
        end
    end

    // output register
    assign out_free = !r_o_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.ld_out) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_out) begin
            r_o_word <= word_masked;
            r_o_bv   <= word_bv;
            r_o_last <= word_last;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_package_word = r_o_word;
    assign o_bytes_valid  = r_o_bv;
    assign o_last_word    = r_o_last;

    // status back to the controller
    always_comb begin
        o_status.is_drain  = r_mode;
        o_status.pending   = (r_wp > POS_W'(HEADER_BYTES));
        o_status.fits      = ({1'b0, r_wp} + (POS_W+1)'(r_left)) <= (POS_W+1)'(PACKAGE_BYTES);
        o_status.byte_last = (r_left == LEFT_W'(1));
        o_status.word_last = word_last;
        o_status.out_free  = out_free;
    end

endmodule

[hw/rtl/can_frame_package_assembler_core.sv]
// top level of the CAN frame package assembler
//
// Input channel: i_valid/o_stall carry one request: i_mode 0 appends a CAN
// frame (i_can_id, i_data_length, i_data_bytes), i_mode 1 ends a drain and
// sends out the open package if it holds any frame. Lengths above 8 are
// clamped to 8. One request is worked on at a time; o_stall stays high
// until it is finished.
// Output channel: o_valid/i_stall carry one 64-bit package word per request
// on that side, first byte in bits 63..56, o_bytes_valid leading bytes
// used, tail bytes zero, o_last_word on the final word of a package.
// Sequence: a frame of 5..13 bytes is accepted and decided on, then moves
// one byte per cycle into the package memory. Emitting a package writes the
// header, then moves one word at a time (up to PACKAGE_BYTES/8, rounded up)
// to the output register, paced by the single memory read port and held
// while the receiver stalls the output register. A frame that does not fit
// makes the open package go out first.
// Reset: write position returns past the 6-byte header, round counter
// clears, output valid drops; memory contents are not cleared.
module can_frame_package_assembler_core
    import cfpa_pkg::*;
#(
    parameter int PACKAGE_BYTES = PACKAGE_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_mode,
    input  logic [31:0] i_can_id,
    input  logic [3:0]  i_data_length,
    input  logic [63:0] i_data_bytes,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_package_word,
    output logic [3:0]  o_bytes_valid,
    output logic        o_last_word
);

    t_cmd    cmd;
    t_status status;

    // sequencing
    cfpa_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // storage and word assembly
    cfpa_datapath #(
        .PACKAGE_BYTES (PACKAGE_BYTES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_mode         (i_mode),
        .i_can_id       (i_can_id),
        .i_data_length  (i_data_length),
        .i_data_bytes   (i_data_bytes),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_package_word (o_package_word),
        .o_bytes_valid  (o_bytes_valid),
        .o_last_word    (o_last_word)
    );

endmodule

[hw/rtl/cfpa_checker.sv]
// port-level checks on the package word stream, bound to the top level
module cfpa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [63:0] o_package_word,
    input logic [3:0]  o_bytes_valid,
    input logic        o_last_word
);

    // an accepted request holds off the next one
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("request accepted without a busy cycle");

    // a stalled word stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("output word dropped while stalled");

    // byte count in range
    a_bv_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_bytes_valid >= 4'd1) && (o_bytes_valid <= 4'd8))
        else $error("byte count out of range");

    // only the last word of a package may be partial
    a_full_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_word |-> o_bytes_valid == 4'd8)
        else $error("partial word before end of package");

    // unused tail bytes read as zero
    a_tail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_bytes_valid < 4'd8) |-> (o_package_word << (o_bytes_valid * 8)) == 64'd0)
        else $error("nonzero bytes past the valid count");

endmodule

bind can_frame_package_assembler_core cfpa_checker u_cfpa_checker (.*);
